// File: rtl/pwrt_pkg.sv
// ----------------------------------------------------------------------------
// pwrt_pkg
// Shared types and constants of the guest page watch table: field widths,
// request codes and the layout of one table entry.
// ----------------------------------------------------------------------------
package pwrt_pkg;

  localparam int REQ_W   = 2;
  localparam int FADDR_W = 52;
  localparam int PAGE_W  = 40;
  localparam int CNT_W   = 16;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int PAGE_BITS_DEF     = 12;

  localparam logic [REQ_W-1:0] REQ_FAULT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ENABLE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DISABLE = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [PAGE_W-1:0] page;
    logic [CNT_W-1:0]  refcnt;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: rtl/pwrt_ram.sv
// ----------------------------------------------------------------------------
// pwrt_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module pwrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/page_watch_refcount_table.sv
// ----------------------------------------------------------------------------
// page_watch_refcount_table
// Guest page watch table: fault checks against global per-kind counters and
// a refcounted table of watched pages, plus enable and disable requests.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over the table memory with
// busy high. An item is taken when start is high and busy is low; exactly
// one result follows, shown for one cycle with out_valid high, and the block
// can take the next item in that same cycle.
// The receiver cannot stall: it must take each result in the cycle it is shown.
// Every page lookup is a sequential walk over the whole table memory, one
// entry per cycle through its single read port. A fault check walks the
// table once, a range request walks it once per page of the range, and
// global, empty, malformed or unknown requests do no walk.
module page_watch_refcount_table #(
  parameter int TABLE_ENTRIES = pwrt_pkg::TABLE_ENTRIES_DEF,
  parameter int PAGE_BITS     = pwrt_pkg::PAGE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pwrt_pkg::REQ_W-1:0]   in_req_type,
  input  logic [pwrt_pkg::FADDR_W-1:0] in_fault_address,
  input  logic                         in_fault_rd,
  input  logic                         in_fault_wr,
  input  logic                         in_fault_ex,
  input  logic                         in_global_request,
  input  logic                         in_watch_read,
  input  logic                         in_watch_write,
  input  logic                         in_watch_exec,
  input  logic [pwrt_pkg::PAGE_W-1:0]  in_first_page,
  input  logic [pwrt_pkg::CNT_W-1:0]   in_page_count,
  output logic                         out_valid,
  output logic                         out_need_stop,
  output logic                         out_bad_request,
  output logic                         out_table_full,
  output logic                         out_watch_active,
  output logic                         out_flush_mappings
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int PW = pwrt_pkg::PAGE_W;
  localparam int NW = pwrt_pkg::CNT_W;

  localparam logic [CW-1:0] SCAN_END  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CLEAR_END = CW'(TABLE_ENTRIES - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       pend_r, pend_nxt;
  logic [AW-1:0]              didx_r, didx_nxt;
  logic [pwrt_pkg::REQ_W-1:0] req_r, req_nxt;
  logic                       glob_r, glob_nxt;
  logic                       wr_r, wr_nxt, ww_r, ww_nxt, wx_r, wx_nxt;
  logic                       rf_r, rf_nxt, wf_r, wf_nxt, xf_r, xf_nxt;
  logic                       nz_r, nz_nxt;
  logic [PW-1:0]              page_r, page_nxt;
  logic [NW-1:0]              rem_r, rem_nxt;
  logic                       hit_r, hit_nxt;
  logic [AW-1:0]              hidx_r, hidx_nxt;
  logic [NW-1:0]              href_r, href_nxt;
  logic                       free_r, free_nxt;
  logic [AW-1:0]              fidx_r, fidx_nxt;
  logic                       full_r, full_nxt;
  logic [NW-1:0]              gr_r, gr_nxt, gw_r, gw_nxt, gx_r, gx_nxt;
  logic [CW-1:0]              vcnt_r, vcnt_nxt;
  logic                       watch_r, watch_nxt;

  logic out_valid_r, out_valid_nxt;
  logic stop_r, stop_nxt;
  logic bad_r, bad_nxt;
  logic ofull_r, ofull_nxt;
  logic oflush_r, oflush_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;
  pwrt_pkg::entry_t        ram_wdata;
  pwrt_pkg::entry_t        ram_rdata;
  logic [pwrt_pkg::ENTRY_W-1:0] ram_rbits;

  logic [pwrt_pkg::FADDR_W-1:0] fault_shift;
  logic                         any_kind;
  logic                         turn_on;
  logic [NW-1:0]                ref_dec;

  assign fault_shift = in_fault_address >> PAGE_BITS;
  assign ram_rdata   = pwrt_pkg::entry_t'(ram_rbits);
  assign any_kind    = wr_r | ww_r | wx_r;
  assign ref_dec     = href_r - 1'b1;
  assign busy        = (state_r != S_IDLE);

  pwrt_ram #(
    .WIDTH (pwrt_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rbits)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    didx_nxt      = didx_r;
    req_nxt       = req_r;
    glob_nxt      = glob_r;
    wr_nxt        = wr_r;
    ww_nxt        = ww_r;
    wx_nxt        = wx_r;
    rf_nxt        = rf_r;
    wf_nxt        = wf_r;
    xf_nxt        = xf_r;
    nz_nxt        = nz_r;
    page_nxt      = page_r;
    rem_nxt       = rem_r;
    hit_nxt       = hit_r;
    hidx_nxt      = hidx_r;
    href_nxt      = href_r;
    free_nxt      = free_r;
    fidx_nxt      = fidx_r;
    full_nxt      = full_r;
    gr_nxt        = gr_r;
    gw_nxt        = gw_r;
    gx_nxt        = gx_r;
    vcnt_nxt      = vcnt_r;
    watch_nxt     = watch_r;
    out_valid_nxt = 1'b0;
    stop_nxt      = stop_r;
    bad_nxt       = bad_r;
    ofull_nxt     = ofull_r;
    oflush_nxt    = oflush_r;
    ram_we        = 1'b0;
    ram_waddr     = cnt_r[AW-1:0];
    ram_wdata     = '0;
    ram_raddr     = cnt_r[AW-1:0];
    turn_on       = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we = 1'b1;
        if (cnt_r == CLEAR_END) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt  = in_req_type;
          glob_nxt = in_global_request;
          wr_nxt   = in_watch_read;
          ww_nxt   = in_watch_write;
          wx_nxt   = in_watch_exec;
          rf_nxt   = in_fault_rd;
          wf_nxt   = in_fault_wr;
          xf_nxt   = in_fault_ex;
          nz_nxt   = (in_page_count != '0);
          rem_nxt  = in_page_count;
          cnt_nxt  = '0;
          pend_nxt = 1'b0;
          hit_nxt  = 1'b0;
          free_nxt = 1'b0;
          full_nxt = 1'b0;
          if (in_req_type == pwrt_pkg::REQ_FAULT) begin
            page_nxt  = fault_shift[PW-1:0];
            state_nxt = S_SCAN;
          end else begin
            page_nxt = in_first_page;
            // A range walk is needed only for a well-formed, non-empty range.
            if ((in_req_type == pwrt_pkg::REQ_ENABLE ||
                 in_req_type == pwrt_pkg::REQ_DISABLE) &&
                (in_watch_read | in_watch_write | in_watch_exec) &&
                !in_global_request && (in_page_count != '0)) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_SCAN: begin
        if (cnt_r != SCAN_END) begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = 1'b1;
          didx_nxt = cnt_r[AW-1:0];
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_UPD;
        end
        if (pend_r) begin
          if (ram_rdata.valid && ram_rdata.page == page_r) begin
            hit_nxt  = 1'b1;
            hidx_nxt = didx_r;
            href_nxt = ram_rdata.refcnt;
          end
          if (!ram_rdata.valid && !free_r) begin
            free_nxt = 1'b1;
            fidx_nxt = didx_r;
          end
        end
      end

      S_UPD: begin
        ram_wdata.page = page_r;
        if (req_r == pwrt_pkg::REQ_ENABLE) begin
          if (hit_r) begin
            ram_we           = 1'b1;
            ram_waddr        = hidx_r;
            ram_wdata.valid  = 1'b1;
            ram_wdata.refcnt = (href_r == '1) ? href_r : href_r + 1'b1;
          end else if (free_r) begin
            ram_we           = 1'b1;
            ram_waddr        = fidx_r;
            ram_wdata.valid  = 1'b1;
            ram_wdata.refcnt = NW'(1);
            vcnt_nxt         = vcnt_r + 1'b1;
          end else begin
            full_nxt = 1'b1;
          end
        end else if (req_r == pwrt_pkg::REQ_DISABLE) begin
          if (hit_r) begin
            // A valid entry always holds a refcount of at least one.
            ram_we           = 1'b1;
            ram_waddr        = hidx_r;
            ram_wdata.valid  = (ref_dec != '0);
            ram_wdata.refcnt = ref_dec;
            if (ref_dec == '0) begin
              vcnt_nxt = vcnt_r - 1'b1;
            end
          end
        end
        if (req_r == pwrt_pkg::REQ_FAULT || rem_r == NW'(1)) begin
          state_nxt = S_FIN;
        end else begin
          rem_nxt   = rem_r - 1'b1;
          page_nxt  = page_r + 1'b1;
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          free_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end

      S_FIN: begin
        stop_nxt   = 1'b0;
        bad_nxt    = 1'b0;
        oflush_nxt = 1'b0;
        if (req_r == pwrt_pkg::REQ_FAULT) begin
          stop_nxt = (rf_r && gr_r != '0) || (wf_r && gw_r != '0) ||
                     (xf_r && gx_r != '0) || hit_r;
        end else if (req_r == pwrt_pkg::REQ_ENABLE ||
                     req_r == pwrt_pkg::REQ_DISABLE) begin
          if (!any_kind) begin
            bad_nxt = 1'b1;
          end else if (req_r == pwrt_pkg::REQ_ENABLE) begin
            if (glob_r) begin
              if (wr_r && gr_r != '1) gr_nxt = gr_r + 1'b1;
              if (ww_r && gw_r != '1) gw_nxt = gw_r + 1'b1;
              if (wx_r && gx_r != '1) gx_nxt = gx_r + 1'b1;
            end
            turn_on = glob_r || nz_r;
            if (turn_on && !watch_r) begin
              watch_nxt  = 1'b1;
              oflush_nxt = 1'b1;
            end
          end else begin
            if (glob_r) begin
              if (wr_r && gr_r != '0) gr_nxt = gr_r - 1'b1;
              if (ww_r && gw_r != '0) gw_nxt = gw_r - 1'b1;
              if (wx_r && gx_r != '0) gx_nxt = gx_r - 1'b1;
            end
            if (gr_nxt == '0 && gw_nxt == '0 && gx_nxt == '0 && vcnt_r == '0) begin
              watch_nxt = 1'b0;
            end
          end
        end
        ofull_nxt     = full_r;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      full_r      <= 1'b0;
      gr_r        <= '0;
      gw_r        <= '0;
      gx_r        <= '0;
      vcnt_r      <= '0;
      watch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      free_r      <= free_nxt;
      full_r      <= full_nxt;
      gr_r        <= gr_nxt;
      gw_r        <= gw_nxt;
      gx_r        <= gx_nxt;
      vcnt_r      <= vcnt_nxt;
      watch_r     <= watch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    didx_r   <= didx_nxt;
    req_r    <= req_nxt;
    glob_r   <= glob_nxt;
    wr_r     <= wr_nxt;
    ww_r     <= ww_nxt;
    wx_r     <= wx_nxt;
    rf_r     <= rf_nxt;
    wf_r     <= wf_nxt;
    xf_r     <= xf_nxt;
    nz_r     <= nz_nxt;
    page_r   <= page_nxt;
    rem_r    <= rem_nxt;
    hidx_r   <= hidx_nxt;
    href_r   <= href_nxt;
    fidx_r   <= fidx_nxt;
    stop_r   <= stop_nxt;
    bad_r    <= bad_nxt;
    ofull_r  <= ofull_nxt;
    oflush_r <= oflush_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_need_stop      = stop_r;
  assign out_bad_request    = bad_r;
  assign out_table_full     = ofull_r;
  assign out_watch_active   = watch_r;
  assign out_flush_mappings = oflush_r;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not make the block busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_vcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vcnt_r <= SCAN_END)
    else $error("valid entry count exceeds table size");

  a_flush_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_flush_mappings) |-> out_watch_active)
    else $error("flush reported while watching is off");
`endif

endmodule

// File: dv/page_watch_refcount_table_tb.sv
// ----------------------------------------------------------------------------
// page_watch_refcount_table_tb
// Self-checking bench for the guest page watch table. A directed table covers
// the reset state, refused and unknown requests, empty ranges, a range that
// wraps past the top page, table overflow and stacked global watches that are
// released back to zero. A random mix of fault checks and watch requests
// follows, aimed at a small set of busy pages. Each result is compared with a
// pinned value or with an in-bench model of the counters and the page table.
// ----------------------------------------------------------------------------
module page_watch_refcount_table_tb;

  localparam int ENTRIES  = pwrt_pkg::TABLE_ENTRIES_DEF;
  localparam int PG_SHIFT = pwrt_pkg::PAGE_BITS_DEF;
  localparam int REQ_W    = pwrt_pkg::REQ_W;
  localparam int FADDR_W  = pwrt_pkg::FADDR_W;
  localparam int PAGE_W   = pwrt_pkg::PAGE_W;
  localparam int CNT_W    = pwrt_pkg::CNT_W;

  localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

  // Kind masks, ordered {read, write, exec}.
  localparam logic [2:0] KIND_NONE = 3'b000;
  localparam logic [2:0] KIND_R    = 3'b100;
  localparam logic [2:0] KIND_W    = 3'b010;
  localparam logic [2:0] KIND_X    = 3'b001;
  localparam logic [2:0] KIND_ALL  = 3'b111;

  localparam logic [PAGE_W-1:0] DIR_BASE = 40'h12_3456_7000;
  localparam logic [PAGE_W-1:0] TOP_BASE = 40'hFF_FFFF_FFF8;

  localparam int RAND_ITEMS   = 760;
  localparam int DRAIN_CYCLES = 2 * (ENTRIES + 3);
  localparam int MAX_MSGS     = 40;
  // The limit leaves ample room for about 900 items of at most 80 page walks
  // each, plus the longest random gap before each, even if every range were long.
  localparam longint CYCLE_LIMIT = 64'd32_000_000;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [FADDR_W-1:0] fault_address;
    logic               fault_rd;
    logic               fault_wr;
    logic               fault_ex;
    logic               global_request;
    logic               watch_read;
    logic               watch_write;
    logic               watch_exec;
    logic [PAGE_W-1:0]  first_page;
    logic [CNT_W-1:0]   page_count;
  } watch_req_t;

  typedef struct packed {
    logic need_stop;
    logic bad_request;
    logic table_full;
    logic watch_active;
    logic flush_mappings;
  } watch_rsp_t;

  typedef struct packed {
    watch_req_t  req;
    logic        pinned;
    watch_rsp_t  rsp;
    int unsigned copies;
  } plan_row_t;

  localparam int REQ_BITS = $bits(watch_req_t);

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [REQ_W-1:0]     in_req_type;
  logic [FADDR_W-1:0]   in_fault_address;
  logic                 in_fault_rd;
  logic                 in_fault_wr;
  logic                 in_fault_ex;
  logic                 in_global_request;
  logic                 in_watch_read;
  logic                 in_watch_write;
  logic                 in_watch_exec;
  logic [PAGE_W-1:0]    in_first_page;
  logic [CNT_W-1:0]     in_page_count;
  logic                 out_valid;
  logic                 out_need_stop;
  logic                 out_bad_request;
  logic                 out_table_full;
  logic                 out_watch_active;
  logic                 out_flush_mappings;

  page_watch_refcount_table #(
    .TABLE_ENTRIES(ENTRIES),
    .PAGE_BITS    (PG_SHIFT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_fault_address  (in_fault_address),
    .in_fault_rd       (in_fault_rd),
    .in_fault_wr       (in_fault_wr),
    .in_fault_ex       (in_fault_ex),
    .in_global_request (in_global_request),
    .in_watch_read     (in_watch_read),
    .in_watch_write    (in_watch_write),
    .in_watch_exec     (in_watch_exec),
    .in_first_page     (in_first_page),
    .in_page_count     (in_page_count),
    .out_valid         (out_valid),
    .out_need_stop     (out_need_stop),
    .out_bad_request   (out_bad_request),
    .out_table_full    (out_table_full),
    .out_watch_active  (out_watch_active),
    .out_flush_mappings(out_flush_mappings)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Model state: global per-kind counters, the page table and the watch flag.
  logic [CNT_W-1:0]  rd_watch;
  logic [CNT_W-1:0]  wr_watch;
  logic [CNT_W-1:0]  ex_watch;
  bit                slot_used [ENTRIES];
  logic [PAGE_W-1:0] slot_page [ENTRIES];
  logic [CNT_W-1:0]  slot_refs [ENTRIES];
  bit                watching;

  watch_rsp_t        pending[$];
  plan_row_t         plan[$];
  watch_rsp_t        want;
  logic [PAGE_W-1:0] hot_base;
  bit                quiet;
  int                n_items;
  int                n_checked;
  int                n_errors;
  int                n_stop;
  int                n_bad;
  int                n_full;
  int                n_flush;
  longint            cycle_count;

  function automatic logic [CNT_W-1:0] sat_up(input logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [CNT_W-1:0] sat_down(input logic [CNT_W-1:0] c);
    return (c == '0) ? c : c - 1'b1;
  endfunction

  function automatic int find_slot(input logic [PAGE_W-1:0] pg);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_used[i] && slot_page[i] == pg) return i;
    end
    return -1;
  endfunction

  // Applies one item to the model and returns the result it should produce.
  function automatic watch_rsp_t apply_request(input watch_req_t r);
    watch_rsp_t        rsp;
    logic [PAGE_W-1:0] pg;
    int                slot;
    bit                any_left;
    bit                enable;
    rsp = '0;
    enable = (r.req_type == pwrt_pkg::REQ_ENABLE);
    if (r.req_type == pwrt_pkg::REQ_FAULT) begin
      pg = PAGE_W'(r.fault_address >> PG_SHIFT);
      rsp.need_stop = (r.fault_rd && rd_watch != 0) || (r.fault_wr && wr_watch != 0) ||
                      (r.fault_ex && ex_watch != 0) || (find_slot(pg) >= 0);
    end else if (enable || r.req_type == pwrt_pkg::REQ_DISABLE) begin
      if (!(r.watch_read || r.watch_write || r.watch_exec)) begin
        rsp.bad_request = 1'b1;
      end else begin
        if (r.global_request) begin
          if (r.watch_read)  rd_watch = enable ? sat_up(rd_watch) : sat_down(rd_watch);
          if (r.watch_write) wr_watch = enable ? sat_up(wr_watch) : sat_down(wr_watch);
          if (r.watch_exec)  ex_watch = enable ? sat_up(ex_watch) : sat_down(ex_watch);
        end else begin
          for (int k = 0; k < int'(r.page_count); k++) begin
            pg = r.first_page + PAGE_W'(k);
            slot = find_slot(pg);
            if (enable) begin
              if (slot < 0) begin
                // A new page takes the lowest free entry, starting from zero refs.
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                  if (!slot_used[i]) slot = i;
                end
                if (slot < 0) begin
                  rsp.table_full = 1'b1;
                end else begin
                  slot_used[slot] = 1'b1;
                  slot_page[slot] = pg;
                  slot_refs[slot] = '0;
                end
              end
              if (slot >= 0) slot_refs[slot] = sat_up(slot_refs[slot]);
            end else if (slot >= 0) begin
              slot_refs[slot] = sat_down(slot_refs[slot]);
              if (slot_refs[slot] == 0) slot_used[slot] = 1'b0;
            end
          end
        end
        if (enable) begin
          if ((r.global_request || r.page_count != 0) && !watching) begin
            watching = 1'b1;
            rsp.flush_mappings = 1'b1;
          end
        end else begin
          any_left = (rd_watch != 0) || (wr_watch != 0) || (ex_watch != 0);
          foreach (slot_used[i]) any_left |= slot_used[i];
          if (!any_left) watching = 1'b0;
        end
      end
    end
    rsp.watch_active = watching;
    return rsp;
  endfunction

  function automatic watch_req_t mk_req(input logic [REQ_W-1:0] kind,
                                        input logic [FADDR_W-1:0] addr,
                                        input logic [2:0] flt, input logic glob,
                                        input logic [2:0] kinds,
                                        input logic [PAGE_W-1:0] first,
                                        input logic [CNT_W-1:0] count);
    watch_req_t r;
    r.req_type = kind;
    r.fault_address = addr;
    {r.fault_rd, r.fault_wr, r.fault_ex} = flt;
    r.global_request = glob;
    {r.watch_read, r.watch_write, r.watch_exec} = kinds;
    r.first_page = first;
    r.page_count = count;
    return r;
  endfunction

  function automatic logic [PAGE_W-1:0] hot_page();
    return (($urandom_range(0, 4) == 0) ? TOP_BASE : hot_base) +
           PAGE_W'($urandom_range(0, 15));
  endfunction

  task automatic row_fixed(input watch_req_t r, input watch_rsp_t rsp);
    plan_row_t row;
    row.req = r;
    row.pinned = 1'b1;
    row.rsp = rsp;
    row.copies = 1;
    plan.push_back(row);
  endtask

  task automatic row_pred(input watch_req_t r, input int unsigned copies);
    plan_row_t row;
    row.req = r;
    row.pinned = 1'b0;
    row.rsp = '0;
    row.copies = copies;
    plan.push_back(row);
  endtask

  task automatic log_error(input string msg);
    n_errors++;
    if (n_errors <= MAX_MSGS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Presents one item after a random gap and returns at the edge that takes it.
  task automatic issue(input watch_req_t r, input logic pinned, input watch_rsp_t pinned_rsp);
    int unsigned gap;
    int unsigned roll;
    watch_rsp_t  predicted;
    if ($urandom_range(0, 63) == 0) quiet = !quiet;
    gap = 0;
    if (!quiet) begin
      roll = $urandom_range(0, 9);
      if (roll >= 9) gap = $urandom_range(4, 30);
      else if (roll >= 5) gap = $urandom_range(1, 3);
    end
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start             <= 1'b1;
    in_req_type       <= r.req_type;
    in_fault_address  <= r.fault_address;
    in_fault_rd       <= r.fault_rd;
    in_fault_wr       <= r.fault_wr;
    in_fault_ex       <= r.fault_ex;
    in_global_request <= r.global_request;
    in_watch_read     <= r.watch_read;
    in_watch_write    <= r.watch_write;
    in_watch_exec     <= r.watch_exec;
    in_first_page     <= r.first_page;
    in_page_count     <= r.page_count;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = apply_request(r);
    pending.push_back(pinned ? pinned_rsp : predicted);
    n_items++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        log_error("result arrived with no item outstanding");
      end else begin
        want = pending.pop_front();
        if (out_need_stop !== want.need_stop)
          log_error($sformatf("result %0d need_stop %b, expected %b",
                              n_checked, out_need_stop, want.need_stop));
        if (out_bad_request !== want.bad_request)
          log_error($sformatf("result %0d bad_request %b, expected %b",
                              n_checked, out_bad_request, want.bad_request));
        if (out_table_full !== want.table_full)
          log_error($sformatf("result %0d table_full %b, expected %b",
                              n_checked, out_table_full, want.table_full));
        if (out_watch_active !== want.watch_active)
          log_error($sformatf("result %0d watch_active %b, expected %b",
                              n_checked, out_watch_active, want.watch_active));
        if (out_flush_mappings !== want.flush_mappings)
          log_error($sformatf("result %0d flush_mappings %b, expected %b",
                              n_checked, out_flush_mappings, want.flush_mappings));
        n_checked++;
        n_stop  += want.need_stop;
        n_bad   += want.bad_request;
        n_full  += want.table_full;
        n_flush += want.flush_mappings;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, pending.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    watch_req_t  r;
    int unsigned roll;
    int          useful;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_req_type       = pwrt_pkg::REQ_FAULT;
    in_fault_address  = '0;
    in_fault_rd       = 1'b0;
    in_fault_wr       = 1'b0;
    in_fault_ex       = 1'b0;
    in_global_request = 1'b0;
    in_watch_read     = 1'b0;
    in_watch_write    = 1'b0;
    in_watch_exec     = 1'b0;
    in_first_page     = '0;
    in_page_count     = '0;
    quiet       = 1'b0;
    cycle_count = 0;
    n_items = 0;
    n_checked = 0;
    n_errors = 0;
    n_stop = 0;
    n_bad = 0;
    n_full = 0;
    n_flush = 0;
    rd_watch = '0;
    wr_watch = '0;
    ex_watch = '0;
    watching = 1'b0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_page[i] = '0;
      slot_refs[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing is watched after reset, whatever the flags say.
    row_fixed(mk_req(pwrt_pkg::REQ_FAULT, '0, KIND_ALL, 1'b0, KIND_NONE, '0, '0), 5'b00000);
    row_fixed(mk_req(pwrt_pkg::REQ_FAULT, '1, KIND_ALL, 1'b1, KIND_ALL, '1, '1), 5'b00000);
    // Requests that name no kind are refused; unknown requests do nothing.
    row_fixed(mk_req(pwrt_pkg::REQ_ENABLE, '1, KIND_ALL, 1'b1, KIND_NONE, '1, '1),
              5'b01000);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_NONE, '0, 16'd5),
              5'b01000);
    row_fixed(mk_req(REQ_UNKNOWN, '1, KIND_ALL, 1'b1, KIND_ALL, '1, '1), 5'b00000);
    // An empty range does not turn watching on.
    row_fixed(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b0, KIND_R, DIR_BASE, '0),
              5'b00000);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_R, DIR_BASE, '0),
              5'b00000);
    // One global read watch, then down past zero.
    row_fixed(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b1, KIND_R, '0, '0), 5'b00011);
    row_fixed(mk_req(pwrt_pkg::REQ_FAULT, '0, KIND_R, 1'b0, KIND_NONE, '0, '0), 5'b10010);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, 52'hA_BCDE_F012_3456, 3'b011, 1'b0, KIND_NONE,
                    '0, '0), 1);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b1, KIND_R, '0, '0), 5'b00000);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b1, KIND_ALL, '0, '0),
              5'b00000);
    // A range that wraps from the top page to page zero.
    row_fixed(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b0, KIND_W, 40'hFF_FFFF_FFFE,
                     16'd3), 5'b00011);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, 52'h0_0000_0000_0ABC, KIND_NONE, 1'b0, KIND_NONE,
                    '0, '0), 1);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, {40'hFF_FFFF_FFFF, 12'hFFF}, KIND_NONE, 1'b0,
                    KIND_NONE, '0, '0), 1);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, 52'h0_0000_0000_1000, KIND_ALL, 1'b0, KIND_NONE,
                    '0, '0), 1);
    row_pred(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b0, KIND_X, 40'hFF_FFFF_FFFE,
                    16'd3), 1);
    row_pred(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_W, 40'hFF_FFFF_FFFE,
                    16'd3), 1);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_R, 40'hFF_FFFF_FFFE,
                     16'd3), 5'b00000);
    // More pages than entries: the tail of the range is skipped.
    row_pred(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b0, KIND_ALL, DIR_BASE, 16'd70),
             1);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, {DIR_BASE + 40'd63, 12'h000}, KIND_NONE, 1'b0,
                    KIND_NONE, '0, '0), 1);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, {DIR_BASE + 40'd64, 12'h800}, KIND_NONE, 1'b0,
                    KIND_NONE, '0, '0), 1);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_ALL, DIR_BASE,
                     16'd70), 5'b00000);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b0, KIND_W, 40'h00_0000_1234,
                     16'd2), 5'b00000);
    // Stack several global watches on all three counters, then release them to zero.
    row_fixed(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b1, KIND_ALL, '0, '0),
              5'b00011);
    row_pred(mk_req(pwrt_pkg::REQ_ENABLE, '0, KIND_NONE, 1'b1, KIND_ALL, '0, '0), 3);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, 52'h5_5555_5555_5555, KIND_X, 1'b0, KIND_NONE,
                    '0, '0), 1);
    row_pred(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b1, KIND_ALL, '0, '0), 3);
    row_pred(mk_req(pwrt_pkg::REQ_FAULT, 52'hA_AAAA_AAAA_AAAA, KIND_R, 1'b0, KIND_NONE,
                    '0, '0), 1);
    row_fixed(mk_req(pwrt_pkg::REQ_DISABLE, '0, KIND_NONE, 1'b1, KIND_ALL, '0, '0),
              5'b00000);
    row_fixed(mk_req(pwrt_pkg::REQ_FAULT, '0, KIND_ALL, 1'b0, KIND_NONE, '0, '0), 5'b00000);

    foreach (plan[i]) begin
      for (int n = 0; n < int'(plan[i].copies); n++) issue(plan[i].req, plan[i].pinned,
                                                            plan[i].rsp);
    end

    // Random part: most traffic lands on a few dozen pages so that faults hit
    // and disables find their entries.
    hot_base = PAGE_W'({$urandom(), $urandom()});
    useful = 0;
    while (useful < RAND_ITEMS) begin
      r = REQ_BITS'({$urandom(), $urandom(), $urandom(), $urandom()});
      roll = $urandom_range(0, 99);
      if (roll < 36) begin
        r.req_type = pwrt_pkg::REQ_FAULT;
        if (roll < 27) r.fault_address = {hot_page(), r.fault_address[PG_SHIFT-1:0]};
      end else if (roll < 86) begin
        r.req_type = (roll < 61) ? pwrt_pkg::REQ_ENABLE : pwrt_pkg::REQ_DISABLE;
        r.global_request = 1'b0;
        r.first_page = hot_page();
        roll = $urandom_range(0, 99);
        if (roll < 3) r.page_count = CNT_W'($urandom_range(40, 80));
        else if (roll < 8) r.page_count = '0;
        else r.page_count = CNT_W'($urandom_range(1, 4));
      end else if (roll < 95) begin
        r.req_type = ($urandom_range(0, 1) != 0) ? pwrt_pkg::REQ_ENABLE
                                                 : pwrt_pkg::REQ_DISABLE;
        r.global_request = 1'b1;
      end else if (roll < 97) begin
        r.req_type = REQ_UNKNOWN;
      end else begin
        r.req_type = ($urandom_range(0, 1) != 0) ? pwrt_pkg::REQ_ENABLE
                                                 : pwrt_pkg::REQ_DISABLE;
        {r.watch_read, r.watch_write, r.watch_exec} = KIND_NONE;
      end
      if (r.req_type == pwrt_pkg::REQ_FAULT ||
          (r.req_type != REQ_UNKNOWN && (r.watch_read || r.watch_write || r.watch_exec)))
        useful++;
      issue(r, 1'b0, '0);
    end
    start <= 1'b0;

    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results for %0d items: %0d stops, %0d refused,",
             n_checked, n_items, n_stop, n_bad);
    $display("%0d table full, %0d flushes, wrapped and overflowing ranges; %0d mismatches.",
             n_full, n_flush, n_errors);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
